### hdl/lcr_pkg.sv
`timescale 1ns / 1ps
// Shared constants, register codes and inter-module types for the load cell reader.
// No dependencies; imported by every module of the block.
package lcr_pkg;

  localparam int DATA_BITS = 24;        // bits clocked out of the converter per conversion
  localparam int SAMPLE_W  = 24;
  localparam int SUM_W     = 32;
  localparam int CNT_W     = 8;
  localparam int GAIN_W    = 2;
  localparam int THR_W     = 24;
  localparam int CNTR_W    = 16;
  localparam int PC_W      = $clog2(DATA_BITS + 1);
  localparam int CMP_W     = ((DATA_BITS > THR_W) ? DATA_BITS : THR_W) + 1;

  // radix-16 restoring divider: four quotient bits per cycle
  localparam int DIV_BITS  = 4;
  localparam int DIV_STEPS = SUM_W / DIV_BITS;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam int APB_AW    = 4;
  localparam int APB_DW    = 32;
  localparam int REG_IDX_W = APB_AW - 2;

  localparam logic [REG_IDX_W-1:0] REG_GAIN = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_AVG  = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_THR  = 2'd2;

  localparam logic [GAIN_W-1:0] GAIN_RST = 2'd3;
  localparam logic [CNT_W-1:0]  AVG_RST  = 8'd1;
  localparam logic [THR_W-1:0]  THR_RST  = 24'd50000;

  typedef struct packed {
    logic [GAIN_W-1:0] gain_pulses;
    logic [CNT_W-1:0]  average_count;
    logic [THR_W-1:0]  change_threshold;
  } cfg_t;

  typedef struct packed {
    logic tick;       // apply one accepted request to the datapath state
    logic div_step;   // advance the divider by one step
    logic out_load;   // move the staged result into the output register
  } cmd_t;

  typedef struct packed {
    logic need_avg;   // the pending request completes an average
  } stat_t;

endpackage

### hdl/lcr_cfg.sv
`timescale 1ns / 1ps
// APB-style configuration registers of the load cell reader.
// Depends on lcr_pkg.
module lcr_cfg (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [lcr_pkg::APB_AW-1:0] paddr,
  input  logic [lcr_pkg::APB_DW-1:0] pwdata,
  output logic [lcr_pkg::APB_DW-1:0] prdata,
  output logic                       pready,
  output lcr_pkg::cfg_t              cfg
);
  import lcr_pkg::*;

  logic                 wr_en;
  logic [REG_IDX_W-1:0] idx;

  assign pready = 1'b1;
  assign idx    = paddr[APB_AW-1:2];
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gain_pulses      <= GAIN_RST;
      cfg.average_count    <= AVG_RST;
      cfg.change_threshold <= THR_RST;
    end else if (wr_en) begin
      case (idx)
        REG_GAIN: cfg.gain_pulses      <= pwdata[GAIN_W-1:0];
        REG_AVG:  cfg.average_count    <= pwdata[CNT_W-1:0];
        REG_THR:  cfg.change_threshold <= pwdata[THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_GAIN: prdata = APB_DW'(cfg.gain_pulses);
      REG_AVG:  prdata = APB_DW'(cfg.average_count);
      REG_THR:  prdata = APB_DW'(cfg.change_threshold);
      default:  prdata = '0;
    endcase
  end

endmodule

### hdl/lcr_ctrl.sv
`timescale 1ns / 1ps
// Controller of the load cell reader: request handshake, divider sequencing,
// result staging and output register occupancy. Depends on lcr_pkg.
module lcr_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  lcr_pkg::stat_t stat,
  output lcr_pkg::cmd_t  cmd
);
  import lcr_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_DIV  = 1'b1;

  logic                 state, state_next;
  logic [DIV_CNT_W-1:0] div_cnt, div_cnt_next;
  logic                 res_full, res_full_next;
  logic                 out_full, out_full_next;
  logic                 accept, move;

  assign in_ready  = (state == ST_IDLE) && !res_full;
  assign accept    = in_valid && in_ready;
  assign move      = res_full && (!out_full || out_ready);
  assign out_valid = out_full;

  always_comb begin
    state_next    = state;
    div_cnt_next  = div_cnt;
    res_full_next = res_full;
    out_full_next = out_full;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (stat.need_avg) begin
            state_next   = ST_DIV;
            div_cnt_next = '0;
          end else begin
            res_full_next = 1'b1;
          end
        end
      end
      ST_DIV: begin
        if (div_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
          state_next    = ST_IDLE;
          div_cnt_next  = '0;
          res_full_next = 1'b1;
        end else begin
          div_cnt_next = div_cnt + 1'b1;
        end
      end
      default: begin
        state_next   = ST_IDLE;
        div_cnt_next = '0;
      end
    endcase
    if (move) begin
      res_full_next = 1'b0;
      out_full_next = 1'b1;
    end else if (out_ready) begin
      out_full_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      div_cnt  <= '0;
      res_full <= 1'b0;
      out_full <= 1'b0;
    end else begin
      state    <= state_next;
      div_cnt  <= div_cnt_next;
      res_full <= res_full_next;
      out_full <= out_full_next;
    end
  end

  always_comb begin
    cmd.tick     = accept;
    cmd.div_step = (state == ST_DIV);
    cmd.out_load = move;
  end

  a_div_entry: assert property (@(posedge clk) disable iff (rst)
    accept && stat.need_avg |=> state == ST_DIV)
    else $error("request needing an average did not start the divider");

  a_div_stage_empty: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV |-> !res_full)
    else $error("staged result present while dividing");

  a_idle_cnt: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> div_cnt == '0)
    else $error("divider step count not cleared in idle");

  a_move_fills_out: assert property (@(posedge clk) disable iff (rst)
    move |=> out_full && !res_full)
    else $error("staged result lost on transfer");

endmodule

### hdl/lcr_dp.sv
`timescale 1ns / 1ps
// Datapath of the load cell reader: serial clock sequencing, bit capture, change
// counters, running sum, radix-16 divider and output register. Depends on lcr_pkg.
module lcr_dp (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         dout,
  input  lcr_pkg::cfg_t                cfg,
  input  lcr_pkg::cmd_t                cmd,
  output lcr_pkg::stat_t               stat,
  output logic                         sck,
  output logic                         sample_valid,
  output logic [lcr_pkg::SAMPLE_W-1:0] sample,
  output logic                         average_valid,
  output logic [lcr_pkg::SAMPLE_W-1:0] average,
  output logic [lcr_pkg::CNTR_W-1:0]   rise_count,
  output logic [lcr_pkg::CNTR_W-1:0]   fall_count
);
  import lcr_pkg::*;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_DATA = 2'd1;
  localparam logic [1:0] PH_GAIN = 2'd2;

  // converter interface state
  logic [1:0]           phase, phase_next;
  logic                 clk_lvl, clk_lvl_next;
  logic [PC_W-1:0]      pulse_cnt, pulse_cnt_next;
  logic [DATA_BITS-1:0] shift_word, shift_word_next;

  // statistics
  logic [SUM_W-1:0]     running_sum;
  logic [CNT_W-1:0]     summed;
  logic [DATA_BITS-1:0] prev_sample;
  logic [CNTR_W-1:0]    rise_total, fall_total;

  // divider; the quotient register doubles as the held average
  logic [SUM_W-1:0]     quotient;
  logic [CNT_W-1:0]     remainder;
  logic [CNT_W-1:0]     divisor;

  // staged flags of the last request
  logic                 res_sck, res_sv, res_av;

  logic                 tick_sck, finish;
  logic [PC_W-1:0]      pc_inc;
  logic [1:0]           ph_tmp;
  logic [DATA_BITS-1:0] s;
  logic [SUM_W-1:0]     sum_new;
  logic [CNT_W-1:0]     summed_inc, cnt_eff;
  logic                 avg_done;
  logic [CMP_W-1:0]     s_x, prev_x, thr_x;
  logic                 is_rise, is_fall;

  logic [CNT_W:0]       dv_t;
  logic [CNT_W-1:0]     dv_r;
  logic [SUM_W-1:0]     dv_q;

  always_comb begin
    phase_next      = phase;
    clk_lvl_next    = clk_lvl;
    pulse_cnt_next  = pulse_cnt;
    shift_word_next = shift_word;
    tick_sck        = 1'b0;
    finish          = 1'b0;
    pc_inc          = pulse_cnt;
    ph_tmp          = phase;
    case (phase)
      PH_DATA, PH_GAIN: begin
        if (!clk_lvl) begin
          tick_sck     = 1'b1;
          clk_lvl_next = 1'b1;
          if (phase == PH_DATA) begin
            shift_word_next = {shift_word[DATA_BITS-2:0], dout};
          end
        end else begin
          clk_lvl_next = 1'b0;
          pc_inc       = pulse_cnt + 1'b1;
          if (phase == PH_DATA && pc_inc >= PC_W'(DATA_BITS)) begin
            ph_tmp = PH_GAIN;
            pc_inc = '0;
          end
          if (ph_tmp == PH_GAIN && pc_inc >= PC_W'(cfg.gain_pulses)) begin
            finish = 1'b1;
            ph_tmp = PH_IDLE;
            pc_inc = '0;
          end
          phase_next     = ph_tmp;
          pulse_cnt_next = pc_inc;
        end
      end
      default: begin
        // idle, also the unused phase code
        phase_next   = PH_IDLE;
        clk_lvl_next = 1'b0;
        if (!dout) begin
          phase_next      = PH_DATA;
          pulse_cnt_next  = '0;
          shift_word_next = '0;
        end
      end
    endcase
  end

  // sample completion: offset binary, change detection, running sum
  assign s          = shift_word ^ {1'b1, {(DATA_BITS - 1){1'b0}}};
  assign sum_new    = running_sum + SUM_W'(s);
  assign summed_inc = summed + 1'b1;
  assign cnt_eff    = (cfg.average_count == '0) ? CNT_W'(1) : cfg.average_count;
  assign avg_done   = finish && (summed_inc >= cnt_eff);
  assign s_x        = CMP_W'(s);
  assign prev_x     = CMP_W'(prev_sample);
  assign thr_x      = CMP_W'(cfg.change_threshold);
  assign is_rise    = s_x > prev_x + thr_x;
  assign is_fall    = prev_x > s_x + thr_x;

  assign stat.need_avg = avg_done;

  // DIV_BITS restoring steps per cycle; remainder always stays below the divisor
  always_comb begin
    dv_r = remainder;
    dv_q = quotient;
    dv_t = '0;
    for (int i = 0; i < DIV_BITS; i++) begin
      dv_t = {dv_r, dv_q[SUM_W-1]};
      dv_q = {dv_q[SUM_W-2:0], 1'b0};
      if (dv_t >= {1'b0, divisor}) begin
        dv_t    = dv_t - {1'b0, divisor};
        dv_q[0] = 1'b1;
      end
      dv_r = dv_t[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      clk_lvl     <= 1'b0;
      pulse_cnt   <= '0;
      shift_word  <= '0;
      running_sum <= '0;
      summed      <= '0;
      prev_sample <= '0;
      rise_total  <= '0;
      fall_total  <= '0;
      quotient    <= '0;
    end else if (cmd.tick) begin
      phase      <= phase_next;
      clk_lvl    <= clk_lvl_next;
      pulse_cnt  <= pulse_cnt_next;
      shift_word <= shift_word_next;
      if (finish) begin
        prev_sample <= s;
        if (is_rise) rise_total <= rise_total + 1'b1;
        if (is_fall) fall_total <= fall_total + 1'b1;
        if (avg_done) begin
          running_sum <= '0;
          summed      <= '0;
          quotient    <= sum_new;
        end else begin
          running_sum <= sum_new;
          summed      <= summed_inc;
        end
      end
    end else if (cmd.div_step) begin
      quotient <= dv_q;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.tick) begin
      res_sck   <= tick_sck;
      res_sv    <= finish;
      res_av    <= avg_done;
      remainder <= '0;
      divisor   <= cnt_eff;
    end else if (cmd.div_step) begin
      remainder <= dv_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      sck           <= res_sck;
      sample_valid  <= res_sv;
      sample        <= SAMPLE_W'(prev_sample);
      average_valid <= res_av;
      average       <= SAMPLE_W'(quotient);
      rise_count    <= rise_total;
      fall_count    <= fall_total;
    end
  end

endmodule

### hdl/load_cell_adc_serial_reader_unit.sv
`timescale 1ns / 1ps
// Load cell converter serial reader: one request per serial clock tick, one result each.
// Usage:
//   Input channel (in_valid/in_ready, dout): one request per tick, carrying the
//   converter data line. Output channel (out_valid/out_ready): one result per
//   request with the clock level to drive (sck), the latest sample, the latest
//   average and the rise/fall counters, with sample_valid/average_valid flags.
//   A result is presented once its request has been staged and moved into the output
//   register; a tick that completes an average first runs the divider (32-bit sum,
//   four quotient bits per cycle). A new request is taken only once the last result
//   has left staging and, after a tick that completes an average, the divider is done.
//   When the receiver stalls, one result waits in the output register and one
//   more request is taken and staged; further requests wait.
//   Reset (rst, synchronous) returns the sequencer to waiting for dout low,
//   clears sum, counters, previous sample and held average, and loads the
//   registers with gain_pulses 3, average_count 1, change_threshold 50000.
//   Registers via the APB port: 0x0 gain_pulses, 0x4 average_count,
//   0x8 change_threshold. Write them only while the block is idle.
// Depends on lcr_pkg, lcr_cfg, lcr_ctrl, lcr_dp.
module load_cell_adc_serial_reader_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         dout,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         sck,
  output logic                         sample_valid,
  output logic [lcr_pkg::SAMPLE_W-1:0] sample,
  output logic                         average_valid,
  output logic [lcr_pkg::SAMPLE_W-1:0] average,
  output logic [lcr_pkg::CNTR_W-1:0]   rise_count,
  output logic [lcr_pkg::CNTR_W-1:0]   fall_count,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [lcr_pkg::APB_AW-1:0]   paddr,
  input  logic [lcr_pkg::APB_DW-1:0]   pwdata,
  output logic [lcr_pkg::APB_DW-1:0]   prdata,
  output logic                         pready
);
  import lcr_pkg::*;

  cfg_t  cfg;
  cmd_t  cmd;
  stat_t stat;

  lcr_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  lcr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  lcr_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .dout          (dout),
    .cfg           (cfg),
    .cmd           (cmd),
    .stat          (stat),
    .sck           (sck),
    .sample_valid  (sample_valid),
    .sample        (sample),
    .average_valid (average_valid),
    .average       (average),
    .rise_count    (rise_count),
    .fall_count    (fall_count)
  );

endmodule

### test/tb_load_cell_adc_serial_reader_unit.sv
`timescale 1ns / 1ps
// Testbench for load_cell_adc_serial_reader_unit: directed and random converter tick streams,
// each result checked against a behavioral reader model kept in step with accepted requests.
// Depends on lcr_pkg and the RTL of the block.
module tb_load_cell_adc_serial_reader_unit;
  import lcr_pkg::*;

  typedef enum logic [1:0] {WAIT_READY, CLOCK_DATA, CLOCK_GAIN} reader_phase_e;

  typedef struct packed {
    logic                sck;
    logic                sample_valid;
    logic [SAMPLE_W-1:0] sample;
    logic                average_valid;
    logic [SAMPLE_W-1:0] average;
    logic [CNTR_W-1:0]   rise_count;
    logic [CNTR_W-1:0]   fall_count;
  } reading_t;

  // top bit of a converter word; flips it to offset binary
  localparam logic [DATA_BITS-1:0] TOP_BIT = {1'b1, {(DATA_BITS - 1){1'b0}}};

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_ready;
  logic                dout;
  logic                out_valid;
  logic                out_ready;
  logic                sck;
  logic                sample_valid;
  logic [SAMPLE_W-1:0] sample;
  logic                average_valid;
  logic [SAMPLE_W-1:0] average;
  logic [CNTR_W-1:0]   rise_count;
  logic [CNTR_W-1:0]   fall_count;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [APB_AW-1:0]   paddr;
  logic [APB_DW-1:0]   pwdata;
  logic [APB_DW-1:0]   prdata;
  logic                pready;

  load_cell_adc_serial_reader_unit dut (.*);

  // reader model state and its copy of the registers
  reader_phase_e        rd_phase  = WAIT_READY;
  logic                 rd_clk    = 1'b0;
  logic [PC_W-1:0]      rd_pulses = '0;
  logic [DATA_BITS-1:0] rd_shift  = '0;
  logic [DATA_BITS-1:0] rd_prev   = '0;
  logic [SUM_W-1:0]     rd_sum    = '0;
  logic [CNT_W-1:0]     rd_summed = '0;
  logic [CNTR_W-1:0]    rd_rises  = '0;
  logic [CNTR_W-1:0]    rd_falls  = '0;
  logic [SAMPLE_W-1:0]  rd_avg    = '0;
  logic [GAIN_W-1:0]    cfg_gain  = GAIN_RST;
  logic [CNT_W-1:0]     cfg_count = AVG_RST;
  logic [THR_W-1:0]     cfg_thr   = THR_RST;

  reading_t    expected_readings[$];
  int unsigned ticks_taken  = 0;
  int unsigned fault_count  = 0;
  int unsigned hold_cycles  = 0;
  bit          steady       = 1'b0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic reading_t clock_reader(input logic d);
    reading_t             r;
    logic [DATA_BITS-1:0] s;
    logic [CNT_W-1:0]     n;
    longint               delta;
    r = '0;
    if (rd_phase == CLOCK_DATA || rd_phase == CLOCK_GAIN) begin
      if (!rd_clk) begin
        r.sck = 1'b1;
        rd_clk = 1'b1;
        if (rd_phase == CLOCK_DATA) rd_shift = {rd_shift[DATA_BITS-2:0], d};
      end else begin
        rd_clk = 1'b0;
        rd_pulses++;
        if (rd_phase == CLOCK_DATA && rd_pulses >= DATA_BITS) begin
          rd_phase = CLOCK_GAIN;
          rd_pulses = '0;
        end
        if (rd_phase == CLOCK_GAIN && rd_pulses >= cfg_gain) begin
          r.sample_valid = 1'b1;
          s = rd_shift ^ TOP_BIT;
          delta = longint'(s) - longint'(rd_prev);
          if (delta > longint'(cfg_thr)) rd_rises++;
          if (delta < -longint'(cfg_thr)) rd_falls++;
          rd_prev = s;
          rd_sum += SUM_W'(s);
          rd_summed++;
          n = (cfg_count == 0) ? CNT_W'(1) : cfg_count;
          if (rd_summed >= n) begin
            rd_avg = SAMPLE_W'(rd_sum / n);
            rd_sum = '0;
            rd_summed = '0;
            r.average_valid = 1'b1;
          end
          rd_phase = WAIT_READY;
          rd_pulses = '0;
        end
      end
    end else begin
      rd_phase = WAIT_READY;
      rd_clk = 1'b0;
      if (!d) begin
        rd_phase = CLOCK_DATA;
        rd_pulses = '0;
        rd_shift = '0;
      end
    end
    r.sample     = SAMPLE_W'(rd_prev);
    r.average    = rd_avg;
    r.rise_count = rd_rises;
    r.fall_count = rd_falls;
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input longint unsigned want,
                               input longint unsigned got);
    fault_count++;
    if (fault_count <= 10) $display("%0t: %s expected %0h, got %0h", $time, what, want, got);
  endtask

  task automatic check_reading(input reading_t got);
    reading_t want;
    if (expected_readings.size() == 0) begin
      fault_count++;
      if (fault_count <= 10) $display("%0t: result with no request outstanding", $time);
      return;
    end
    want = expected_readings.pop_front();
    if (got.sck !== want.sck) flag_mismatch("sck", want.sck, got.sck);
    if (got.sample_valid !== want.sample_valid)
      flag_mismatch("sample_valid", want.sample_valid, got.sample_valid);
    if (got.sample !== want.sample) flag_mismatch("sample", want.sample, got.sample);
    if (got.average_valid !== want.average_valid)
      flag_mismatch("average_valid", want.average_valid, got.average_valid);
    if (got.average !== want.average) flag_mismatch("average", want.average, got.average);
    if (got.rise_count !== want.rise_count)
      flag_mismatch("rise_count", want.rise_count, got.rise_count);
    if (got.fall_count !== want.fall_count)
      flag_mismatch("fall_count", want.fall_count, got.fall_count);
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        expected_readings.push_back(clock_reader(dout));
        ticks_taken++;
      end
      if (out_valid && out_ready)
        check_reading({sck, sample_valid, sample, average_valid, average, rise_count,
                       fall_count});
    end
  end

  // receiver: random stalls, or a counted hold-off when one is requested
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_ready <= 1'b0;
      hold_cycles--;
    end else begin
      out_ready <= steady || ($urandom_range(0, 99) >= 10);
    end
  end

  // called and returns at a falling edge; returns once the request is taken
  task automatic send_tick(input logic d);
    int unsigned seen;
    if (!steady && $urandom_range(0, 99) < 10) begin
      in_valid <= 1'b0;
      dout <= 1'($urandom);
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    seen = ticks_taken;
    in_valid <= 1'b1;
    dout <= d;
    do @(negedge clk); while (ticks_taken == seen);
  endtask

  // feed ticks until the reader is idle again; data bits come from word
  task automatic finish_conversion(input logic [DATA_BITS-1:0] word);
    while (rd_phase != WAIT_READY)
      send_tick((rd_phase == CLOCK_DATA && !rd_clk) ? word[DATA_BITS - 1 - rd_pulses]
                                                    : 1'($urandom));
  endtask

  task automatic run_conversion(input logic [DATA_BITS-1:0] word);
    finish_conversion(DATA_BITS'($urandom));
    repeat ($urandom_range(0, 3)) send_tick(1'b1);
    send_tick(1'b0);
    finish_conversion(word);
  endtask

  task automatic settle_block();
    in_valid <= 1'b0;
    while (expected_readings.size() != 0) @(negedge clk);
    // covers the divider on a trailing average
    repeat (12) @(negedge clk);
  endtask

  task automatic set_reg(input logic [REG_IDX_W-1:0] idx, input logic [APB_DW-1:0] value);
    settle_block();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_GAIN: cfg_gain  = value[GAIN_W-1:0];
      REG_AVG:  cfg_count = value[CNT_W-1:0];
      REG_THR:  cfg_thr   = value[THR_W-1:0];
      default:  ;
    endcase
  endtask

  // idle line, then one conversion with reset settings
  task automatic test_default_conversions();
    repeat (4) send_tick(1'b1);
    run_conversion('0);
  endtask

  task automatic test_gain_pulses();
    for (int g = 0; g < 3; g++) begin
      set_reg(REG_GAIN, APB_DW'(g));
      run_conversion(DATA_BITS'($urandom));
    end
    set_reg(REG_GAIN, APB_DW'(GAIN_RST));
  endtask

  task automatic test_averaging();
    set_reg(REG_AVG, APB_DW'(0));
    run_conversion(DATA_BITS'($urandom));
    set_reg(REG_AVG, APB_DW'(255));
    run_conversion('1);
    // count lowered to what is already summed
    set_reg(REG_AVG, APB_DW'(AVG_RST));
    run_conversion(DATA_BITS'($urandom));
  endtask

  task automatic test_thresholds();
    logic [DATA_BITS-1:0] word;
    word = DATA_BITS'($urandom_range(1, 1000));
    set_reg(REG_THR, APB_DW'(0));
    run_conversion(word);
    run_conversion(word + 1'b1);
    run_conversion(word);
    set_reg(REG_THR, APB_DW'({THR_W{1'b1}}));
    run_conversion(TOP_BIT);
    run_conversion(~TOP_BIT);
    set_reg(REG_THR, APB_DW'(THR_RST));
  endtask

  // long receiver stall while requests keep coming
  task automatic test_output_stall();
    hold_cycles = 150;
    run_conversion(DATA_BITS'($urandom));
  endtask

  task automatic test_random_traffic();
    int unsigned          first_tick;
    int unsigned          round;
    logic [DATA_BITS-1:0] word;
    longint               offset;
    longint               target;
    first_tick = ticks_taken;
    round = 0;
    while (ticks_taken - first_tick < 100) begin
      set_reg(REG_GAIN, $urandom_range(0, 3));
      case ($urandom_range(0, 5))
        0:       set_reg(REG_AVG, APB_DW'(0));
        1:       set_reg(REG_AVG, APB_DW'(255));
        default: set_reg(REG_AVG, $urandom_range(1, 6));
      endcase
      case ($urandom_range(0, 3))
        0:       set_reg(REG_THR, APB_DW'(0));
        1:       set_reg(REG_THR, APB_DW'({THR_W{1'b1}}));
        2:       set_reg(REG_THR, $urandom_range(0, 2000000));
        default: set_reg(REG_THR, $urandom);
      endcase
      steady = (round == 0);
      // stray ticks, possibly starting a conversion that then runs with junk data
      if ($urandom_range(0, 99) < 15) repeat ($urandom_range(1, 6)) send_tick(1'($urandom));
      finish_conversion(DATA_BITS'($urandom));
      case ($urandom_range(0, 9))
        0: word = {1'($urandom), {(DATA_BITS - 1){1'($urandom)}}};
        1, 2: begin
          // land on or just past the threshold from the previous sample
          offset = longint'(cfg_thr) + longint'($urandom_range(0, 1));
          if ($urandom_range(0, 1)) offset = -offset;
          target = longint'(rd_prev) + offset;
          if (target >= 0 && target < (longint'(1) << DATA_BITS))
            word = target[DATA_BITS-1:0] ^ TOP_BIT;
          else
            word = DATA_BITS'($urandom);
        end
        default: word = DATA_BITS'($urandom);
      endcase
      run_conversion(word);
      round++;
    end
    steady = 1'b0;
  endtask

  initial begin
    rst      = 1'b1;
    in_valid = 1'b0;
    dout     = 1'b1;
    out_ready = 1'b0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_default_conversions();
    test_gain_pulses();
    test_averaging();
    test_thresholds();
    test_output_stall();
    test_random_traffic();
    settle_block();
    if (fault_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### files.f
hdl/lcr_pkg.sv
hdl/lcr_cfg.sv
hdl/lcr_ctrl.sv
hdl/lcr_dp.sv
hdl/load_cell_adc_serial_reader_unit.sv
test/tb_load_cell_adc_serial_reader_unit.sv
